FILE: rtl/fds_pkg.sv
// Shared types, constants and the checksum helper for the directory entry scanner.
// Used by fds_run_tracker and fat_directory_entry_scanner_core.
`timescale 1ns / 1ps

package fds_pkg;

	localparam logic [7:0] ATTR_LONG    = 8'h0F;
	localparam logic [7:0] ATTR_INVALID = 8'hC8;
	localparam logic [7:0] ATTR_DIR     = 8'h10;
	localparam logic [7:0] SEQ_START    = 8'h40;
	localparam logic [7:0] SEQ_END_MARK = 8'h00;
	localparam logic [7:0] DELETED_MARK = 8'hE5;
	localparam int         SHORT_NAME_LEN = 11;
	localparam int         HEAD_BYTES     = 6;	// name bytes folded in the first stage

	localparam logic KIND_ENTRY = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef struct packed {
		logic [63:0] name_bytes;
		logic [23:0] ext_bytes;
		logic [7:0]  attr_byte;
		logic [7:0]  long_checksum;
		logic [15:0] cluster_high;
		logic [15:0] cluster_low;
		logic [31:0] entry_size;
	} fds_in_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] start_cluster;
		logic [31:0] file_size;
		logic        is_directory;
		logic        long_name_valid;
		logic [5:0]  long_name_parts;
		logic [7:0]  short_checksum;
	} fds_out_t;

	// one step of the rotate-right-and-add short name checksum
	function automatic logic [7:0] cs_step(input logic [7:0] sum, input logic [7:0] b);
		cs_step = {sum[0], sum[7:1]} + b;
	endfunction

endpackage

FILE: rtl/fat_directory_entry_scanner_core.sv
// FAT32 directory entry scanner: top level with the pipeline registers.
// Depends on fds_pkg and fds_run_tracker.
`timescale 1ns / 1ps
//
// Usage
//   entry channel: one 32-byte directory entry (split into fields) per request,
//     taken at a clock edge with entry_valid high and entry_stall low.
//   result channel: at most one result per entry, offered with result_valid;
//     the receiver holds it with result_stall.
//   End-of-directory entries give a result with kind set and all else zero;
//   deleted, long-name and invalid entries give none.
// Throughput: one entry per cycle while the output is not held. A result passes
//   the input register, the checksum stage and the output register before it
//   is offered. The 11-step checksum chain is split over the first two
//   stages, the run state is updated in the second one.
// Stall: the whole pipe holds while a result waits and result_stall is high;
//   entry_stall follows in that same cycle, otherwise entries flow freely.
// Reset: clears the stage valid flags, the output valid and the long-name
//   run state; no result is pending afterwards.

module fat_directory_entry_scanner_core
	import fds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     entry_valid,
	output logic     entry_stall,
	input  fds_in_t  entry,
	output logic     result_valid,
	input  logic     result_stall,
	output fds_out_t result
);

	logic       adv;
	logic       valid_s1;
	fds_in_t    item_s1;
	logic       valid_s2;
	fds_in_t    item_s2;
	logic [7:0] head_sum_s2;
	logic [7:0] head_sum;
	logic       emit;
	fds_out_t   res_d;
	logic       out_valid_q;
	fds_out_t   out_q;

	assign adv         = !(out_valid_q && result_stall);
	assign entry_stall = !adv;

	// first six name bytes of the checksum
	always_comb begin
		logic [7:0] s;
		s = 8'h00;
		for (int i = 0; i < HEAD_BYTES; i++) begin
			s = cs_step(s, item_s1.name_bytes[8*i +: 8]);
		end
		head_sum = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= entry_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (entry_valid)
				item_s1 <= entry;
			item_s2     <= item_s1;
			head_sum_s2 <= head_sum;
			out_q       <= res_d;
		end
	end

	fds_run_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (valid_s2 && adv),
		.item     (item_s2),
		.head_sum (head_sum_s2),
		.emit     (emit),
		.result   (res_d)
	);

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: rtl/fds_run_tracker.sv
// Long-name run state and result decision for one directory entry per cycle while en is high.
// Finishes the short name checksum; depends on fds_pkg.
`timescale 1ns / 1ps

module fds_run_tracker
	import fds_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  fds_in_t       item,
	input  logic [7:0]    head_sum,
	output logic          emit,
	output fds_out_t      result
);

	logic       in_run_q;
	logic [5:0] exp_order_q;
	logic [5:0] run_len_q;
	logic [7:0] run_cs_q;
	logic       agree_q;

	logic       in_run_d;
	logic [5:0] exp_order_d;
	logic [5:0] run_len_d;
	logic [7:0] run_cs_d;
	logic       agree_d;

	logic [7:0] seq;
	logic [7:0] sum;
	logic [5:0] next_order;
	logic       is_dir;
	logic       name_ok;

	assign seq        = item.name_bytes[7:0];
	assign next_order = exp_order_q - 6'd1;
	assign is_dir     = (item.attr_byte & ATTR_DIR) != 8'h00;

	// remaining name bytes and the extension
	always_comb begin
		logic [7:0] s;
		s = head_sum;
		for (int i = HEAD_BYTES; i < 8; i++) begin
			s = cs_step(s, item.name_bytes[8*i +: 8]);
		end
		for (int i = 0; i < SHORT_NAME_LEN - 8; i++) begin
			s = cs_step(s, item.ext_bytes[8*i +: 8]);
		end
		sum = s;
	end

	assign name_ok = in_run_q && (exp_order_q == 6'd1) && agree_q && (run_cs_q == sum);

	always_comb begin
		in_run_d    = in_run_q;
		exp_order_d = exp_order_q;
		run_len_d   = run_len_q;
		run_cs_d    = run_cs_q;
		agree_d     = agree_q;
		emit        = 1'b0;
		result      = '0;
		if (seq == SEQ_END_MARK) begin
			in_run_d    = 1'b0;
			exp_order_d = '0;
			run_len_d   = '0;
			run_cs_d    = '0;
			agree_d     = 1'b1;
			emit        = 1'b1;
			result.kind = KIND_END;
		end else if (seq == DELETED_MARK
				|| (item.attr_byte != ATTR_LONG && (item.attr_byte & ATTR_INVALID) != 8'h00)) begin
			in_run_d    = 1'b0;
			exp_order_d = '0;
			run_len_d   = '0;
			run_cs_d    = '0;
			agree_d     = 1'b1;
		end else if (item.attr_byte == ATTR_LONG) begin
			if ((seq & SEQ_START) != 8'h00) begin
				if (seq[5:0] == 6'd0) begin
					in_run_d    = 1'b0;
					exp_order_d = '0;
					run_len_d   = '0;
					run_cs_d    = '0;
				end else begin
					in_run_d    = 1'b1;
					exp_order_d = seq[5:0];
					run_len_d   = seq[5:0];
					run_cs_d    = item.long_checksum;
				end
				agree_d = 1'b1;
			end else if (in_run_q) begin
				// whole order byte must equal the next lower order number
				if (exp_order_q <= 6'd1 || seq != {2'b00, next_order}) begin
					in_run_d    = 1'b0;
					exp_order_d = '0;
					run_len_d   = '0;
					run_cs_d    = '0;
					agree_d     = 1'b1;
				end else begin
					exp_order_d = next_order;
					if (item.long_checksum != run_cs_q)
						agree_d = 1'b0;
				end
			end
		end else begin
			emit                   = 1'b1;
			result.kind            = KIND_ENTRY;
			result.start_cluster   = {item.cluster_high, item.cluster_low};
			result.file_size       = is_dir ? 32'd0 : item.entry_size;
			result.is_directory    = is_dir;
			result.long_name_valid = name_ok;
			result.long_name_parts = name_ok ? run_len_q : 6'd0;
			result.short_checksum  = sum;
			in_run_d    = 1'b0;
			exp_order_d = '0;
			run_len_d   = '0;
			run_cs_d    = '0;
			agree_d     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q    <= 1'b0;
			exp_order_q <= '0;
			run_len_q   <= '0;
			run_cs_q    <= '0;
			agree_q     <= 1'b1;
		end else if (en) begin
			in_run_q    <= in_run_d;
			exp_order_q <= exp_order_d;
			run_len_q   <= run_len_d;
			run_cs_q    <= run_cs_d;
			agree_q     <= agree_d;
		end
	end

	// an open run always has a live order number no larger than its length
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q |-> (exp_order_q != 6'd0 && exp_order_q <= run_len_q))
		else $error("open run with bad order number");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_run_q |-> (exp_order_q == 6'd0 && run_len_q == 6'd0 && agree_q))
		else $error("run state not cleared when closed");

	a_valid_parts: assert property (@(posedge clk) disable iff (!arst_n)
		(en && emit && result.long_name_valid) |-> (result.long_name_parts != 6'd0))
		else $error("valid long name with no parts");

	a_short_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(en && emit) |=> !in_run_q)
		else $error("run left open after a result");

endmodule

FILE: tb/tb_fat_directory_entry_scanner_core.sv
// Self-checking testbench for fat_directory_entry_scanner_core: directory entries go in,
// predicted results are queued and compared field by field. Needs fds_pkg and the RTL.
`timescale 1ns / 1ps

module tb_fat_directory_entry_scanner_core;
	import fds_pkg::*;

	localparam int         WATCHDOG_LIMIT  = 3000;
	localparam int         DRAIN_CYCLES    = 8;
	localparam int         MAX_REPORTS     = 60;
	localparam int         LFN_MAX_PARTS   = 63;
	localparam logic [7:0] SHORT_ATTR_BITS = 8'h37;	// ro, hidden, system, dir, archive
	localparam logic [7:0] KANJI_LEAD      = 8'h05;

	typedef enum int {
		FLAW_NONE,
		FLAW_SUM,
		FLAW_SKIP,
		FLAW_DELETED,
		FLAW_BAD_ATTR,
		FLAW_END,
		FLAW_RESTART,
		FLAW_HIGH_BIT,
		FLAW_COUNT
	} run_flaw_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     entry_valid = 1'b0;
	logic     entry_stall;
	fds_in_t  entry = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	fds_out_t result;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int entries_sent = 0;
	int failures = 0;
	int idle_cycles = 0;

	fds_out_t pending_results[$];

	// long-name run state of the predictor
	logic       lfn_open = 1'b0;
	logic [5:0] lfn_order = '0;
	logic [5:0] lfn_parts = '0;
	logic [7:0] lfn_sum = '0;
	logic       lfn_sums_match = 1'b1;

	fat_directory_entry_scanner_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.entry_valid(entry_valid),
		.entry_stall(entry_stall),
		.entry(entry),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] name_checksum(input fds_in_t e);
		logic [87:0] raw;
		logic [7:0]  s;
		raw = {e.ext_bytes, e.name_bytes};
		s = 8'h00;
		for (int i = 0; i < SHORT_NAME_LEN; i++)
			s = {s[0], s[7:1]} + raw[8*i +: 8];
		return s;
	endfunction

	task automatic close_name_run();
		lfn_open = 1'b0;
		lfn_order = '0;
		lfn_parts = '0;
		lfn_sum = '0;
		lfn_sums_match = 1'b1;
	endtask

	// predicts the result, if any, of one accepted entry
	task automatic scan_entry_model(input fds_in_t e);
		logic [7:0] lead;
		logic [7:0] sum;
		logic [5:0] nxt;
		fds_out_t   r;
		lead = e.name_bytes[7:0];
		r = '0;
		if (lead == SEQ_END_MARK) begin
			close_name_run();
			r.kind = KIND_END;
			pending_results.push_back(r);
		end else if (lead == DELETED_MARK) begin
			close_name_run();
		end else if (e.attr_byte == ATTR_LONG) begin
			if ((lead & SEQ_START) != 8'h00) begin
				if (lead[5:0] == 6'd0) begin
					close_name_run();
				end else begin
					lfn_open = 1'b1;
					lfn_order = lead[5:0];
					lfn_parts = lead[5:0];
					lfn_sum = e.long_checksum;
					lfn_sums_match = 1'b1;
				end
			end else if (lfn_open) begin
				nxt = lfn_order - 6'd1;
				// whole byte must match, so a stray top bit breaks the run
				if (lfn_order <= 6'd1 || lead != {2'b00, nxt}) begin
					close_name_run();
				end else begin
					lfn_order = nxt;
					if (e.long_checksum != lfn_sum)
						lfn_sums_match = 1'b0;
				end
			end
		end else if ((e.attr_byte & ATTR_INVALID) != 8'h00) begin
			close_name_run();
		end else begin
			sum = name_checksum(e);
			r.kind = KIND_ENTRY;
			r.start_cluster = {e.cluster_high, e.cluster_low};
			r.is_directory = (e.attr_byte & ATTR_DIR) != 8'h00;
			r.file_size = r.is_directory ? 32'd0 : e.entry_size;
			r.long_name_valid = lfn_open && lfn_order == 6'd1 && lfn_sums_match
				&& lfn_sum == sum;
			r.long_name_parts = r.long_name_valid ? lfn_parts : 6'd0;
			r.short_checksum = sum;
			close_name_run();
			pending_results.push_back(r);
		end
	endtask

	function automatic fds_in_t mk_short();
		fds_in_t e;
		e.name_bytes = {$urandom, $urandom};
		e.ext_bytes = 24'($urandom);
		e.attr_byte = 8'($urandom) & SHORT_ATTR_BITS;
		e.long_checksum = 8'($urandom);
		e.cluster_high = 16'($urandom);
		e.cluster_low = 16'($urandom);
		e.entry_size = $urandom;
		if (e.name_bytes[7:0] == SEQ_END_MARK || e.name_bytes[7:0] == DELETED_MARK)
			e.name_bytes[7:0] = KANJI_LEAD;
		return e;
	endfunction

	function automatic fds_in_t mk_long(input logic [7:0] lead, input logic [7:0] cs);
		fds_in_t e;
		e = mk_short();
		e.name_bytes[7:0] = lead;
		e.attr_byte = ATTR_LONG;
		e.long_checksum = cs;
		return e;
	endfunction

	function automatic fds_in_t noise_entry();
		fds_in_t e;
		int      pick;
		e = mk_short();
		e.name_bytes = {$urandom, $urandom};
		e.attr_byte = 8'($urandom);
		pick = $urandom_range(9);
		case (pick)
			0: e.name_bytes[7:0] = SEQ_END_MARK;
			1: e.name_bytes[7:0] = DELETED_MARK;
			2: e.name_bytes[7:0] = KANJI_LEAD;
			3, 4: e.name_bytes[6] = 1'b1;
			default: ;
		endcase
		pick = $urandom_range(9);
		if (pick < 4)
			e.attr_byte = ATTR_LONG;
		else if (pick < 7)
			e.attr_byte = 8'($urandom) & SHORT_ATTR_BITS;
		return e;
	endfunction

	// offers one request at the falling edge, holds it until taken
	task automatic send_entry(input fds_in_t e);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			entry_valid <= 1'b0;
			@(negedge clk);
		end
		entry_valid <= 1'b1;
		entry <= e;
		do begin
			@(posedge clk);
			taken = !entry_stall;
			if (taken) begin
				scan_entry_model(e);
				entries_sent++;
			end
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// long-name run followed by its short entry, optionally broken in one place
	task automatic send_name_run(input int parts, input run_flaw_t flaw);
		fds_in_t    sh;
		fds_in_t    e;
		logic [7:0] cs;
		logic [7:0] ord;
		int         bad_at;
		sh = mk_short();
		cs = name_checksum(sh);
		bad_at = $urandom_range(parts - 1);
		for (int k = 0; k < parts; k++) begin
			ord = 8'(parts - k);
			e = mk_long((k == 0) ? (SEQ_START | ord) : ord, cs);
			if (k == bad_at) begin
				case (flaw)
					FLAW_SUM: e.long_checksum = cs ^ (8'h01 << $urandom_range(7));
					FLAW_DELETED: begin
						e.name_bytes[7:0] = DELETED_MARK;
						send_entry(e);
						e.name_bytes[7:0] = (k == 0) ? (SEQ_START | ord) : ord;
					end
					FLAW_BAD_ATTR: begin
						e = noise_entry();
						e.name_bytes[7:0] = KANJI_LEAD;
						e.attr_byte = (8'($urandom) & 8'hF7) | ATTR_INVALID;
						send_entry(e);
						e = mk_long((k == 0) ? (SEQ_START | ord) : ord, cs);
					end
					FLAW_END: send_entry(mk_long(SEQ_END_MARK, cs));
					FLAW_RESTART: send_entry(mk_long(SEQ_START | (8'($urandom) & 8'h3F), cs));
					FLAW_HIGH_BIT: e.name_bytes[7] = 1'b1;
					default: ;
				endcase
			end
			if (!(k == bad_at && flaw == FLAW_SKIP))
				send_entry(e);
		end
		send_entry(sh);
	endtask

	function automatic run_flaw_t pick_flaw();
		if ($urandom_range(3) != 0)
			return FLAW_NONE;
		return run_flaw_t'($urandom_range(FLAW_COUNT - 1, FLAW_SUM));
	endfunction

	function automatic int pick_parts();
		if ($urandom_range(9) < 8)
			return $urandom_range(4, 1);
		return $urandom_range(20, 5);
	endfunction

	task automatic test_directed_cases();
		fds_in_t    sh;
		fds_in_t    e;
		logic [7:0] cs;
		// end of directory with every other bit set
		e = '1;
		e.name_bytes[7:0] = SEQ_END_MARK;
		send_entry(e);
		// all-ones directory entry, size must read as zero
		e = '1;
		e.attr_byte = SHORT_ATTR_BITS;
		send_entry(e);
		e = '0;
		e.name_bytes = {8{8'h20}};
		e.ext_bytes = {3{8'h20}};
		e.entry_size = '1;
		send_entry(e);
		e = mk_short();
		e.name_bytes[7:0] = DELETED_MARK;
		send_entry(e);
		e = mk_short();
		e.name_bytes[7:0] = KANJI_LEAD;
		send_entry(e);
		// complete two-part run
		sh = mk_short();
		cs = name_checksum(sh);
		send_entry(mk_long(SEQ_START | 8'd2, cs));
		send_entry(mk_long(8'd1, cs));
		send_entry(sh);
		// run that never reaches order one
		send_entry(mk_long(SEQ_START | 8'd3, cs));
		send_entry(mk_long(8'd2, cs));
		send_entry(sh);
		// start flag with order zero
		send_entry(mk_long(SEQ_START, cs));
		send_entry(mk_long(8'd1, cs));
		send_entry(sh);
		// order skipped
		send_entry(mk_long(SEQ_START | 8'd3, cs));
		send_entry(mk_long(8'd1, cs));
		send_entry(sh);
		// checksums disagree within the run
		send_entry(mk_long(SEQ_START | 8'd2, cs));
		send_entry(mk_long(8'd1, cs ^ 8'h01));
		send_entry(sh);
		// invalid attribute between run and short entry
		send_entry(mk_long(SEQ_START | 8'd1, cs));
		e = mk_short();
		e.attr_byte = ATTR_INVALID;
		send_entry(e);
		send_entry(sh);
		// long entry with no open run is ignored
		send_entry(mk_long(8'd1, cs));
		send_entry(sh);
	endtask

	task automatic test_name_runs(input int target, input bit with_longest);
		int start;
		start = entries_sent;
		if (with_longest)
			send_name_run(LFN_MAX_PARTS, FLAW_NONE);
		while (entries_sent - start < target) begin
			send_name_run(pick_parts(), pick_flaw());
			if ($urandom_range(9) == 0)
				send_entry(noise_entry());
		end
	endtask

	task automatic test_random_mix(input int target);
		int start;
		start = entries_sent;
		while (entries_sent - start < target) begin
			if ($urandom_range(1) == 0)
				send_name_run(pick_parts(), pick_flaw());
			else
				repeat ($urandom_range(3, 1)) send_entry(noise_entry());
		end
	endtask

	// sender stops until every result is out, then carries on
	task automatic test_drain_pause();
		send_name_run(3, FLAW_NONE);
		entry_valid <= 1'b0;
		wait_drained();
		send_name_run(2, FLAW_NONE);
	endtask

	// receiver holds off while requests keep coming, so the pipe fills
	task automatic test_backpressure();
		hold_cycles = 300;
		repeat (24) send_entry(mk_short());
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic check_field(input string fld, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			if (failures < MAX_REPORTS)
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, fld, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : check_results
		fds_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				if (failures < MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual 0x%0h",
						$time, result);
				failures++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(result.kind));
				check_field("start_cluster", want.start_cluster, result.start_cluster);
				check_field("file_size", want.file_size, result.file_size);
				check_field("is_directory", 32'(want.is_directory),
					32'(result.is_directory));
				check_field("long_name_valid", 32'(want.long_name_valid),
					32'(result.long_name_valid));
				check_field("long_name_parts", 32'(want.long_name_parts),
					32'(result.long_name_parts));
				check_field("short_checksum", 32'(want.short_checksum),
					32'(result.short_checksum));
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((entry_valid && !entry_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 6;
		recv_stall_pct = 81;
		test_directed_cases();
		test_name_runs(220, 1'b1);

		send_idle_pct = 81;
		recv_stall_pct = 6;
		test_random_mix(180);
		test_drain_pause();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();
		test_name_runs(200, 1'b0);

		entry_valid <= 1'b0;
		wait_drained();
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fds_pkg.sv
rtl/fds_run_tracker.sv
rtl/fat_directory_entry_scanner_core.sv
tb/tb_fat_directory_entry_scanner_core.sv
